// ===== rtl/ahp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ahp_pkg;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_TOO_SHORT = 3'd1;
    localparam logic [2:0] STATUS_BAD_MAGIC = 3'd2;
    localparam logic [2:0] STATUS_BAD_DIMS  = 3'd3;
    localparam logic [2:0] STATUS_TOO_SMALL = 3'd4;

    localparam logic [31:0] MAGIC_WORD = 32'h5CA1AB13;
    localparam logic [31:0] HDR_LEN    = 32'd16;
    localparam logic [3:0]  LAST_POS   = 4'd15;

    localparam int FMT_COUNT = 14;
    localparam logic [3:0] BLK_X [FMT_COUNT] = '{4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd8, 4'd8,
                                                 4'd8, 4'd10, 4'd10, 4'd10, 4'd10, 4'd12,
                                                 4'd12};
    localparam logic [3:0] BLK_Y [FMT_COUNT] = '{4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd5, 4'd6,
                                                 4'd8, 4'd5, 4'd6, 4'd8, 4'd10, 4'd10,
                                                 4'd12};

    // One classified header, passed from the front end to the back end
    typedef struct packed {
        logic [2:0]  pre_status;
        logic [3:0]  fmt;
        logic [3:0]  bx;
        logic [3:0]  by;
        logic [23:0] width;
        logic [23:0] height;
        logic [23:0] depth;
        logic [27:0] avail;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIV    = 5'b00010,
        S_MUL_XY = 5'b00100,
        S_MUL_Z  = 5'b01000,
        S_FINISH = 5'b10000
    } back_state_t;

    // Returns {match, index}; block sizes in the table are unique
    function automatic logic [4:0] fmt_lookup(input logic [7:0] bx, input logic [7:0] by);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 0; i < FMT_COUNT; i++) begin
            if (bx == {4'd0, BLK_X[i]} && by == {4'd0, BLK_Y[i]}) begin
                r = {1'b1, 4'(i)};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/astc_header_parser.sv =====
// Channel   Direction  Handshake             Payload
// header    in         push / full           header_byte
// result    out        pop / empty           status, format_index, width, height,
//                                            depth, payload_bytes
// config    in         cfg_valid / cfg_ready cfg_data (file_length)
//
// One header byte per cycle is taken unless full holds it; after the sixteenth byte the result is set by
// the two 7-step radix-16 block-count dividers and two multiplies, which a header failing a length,
// magic or block-size check skips; the back end takes a new header only after the last is handed on.
// Reset clears the byte position, the header queue, the sequencer and file_length.
// full rises only on the sixteenth byte while two headers wait for the back end.
// A result stays on the ports until popped; the back end waits behind it.
`timescale 1ns / 1ps
`default_nettype none

module astc_header_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  header_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       status,
    output logic [3:0]       format_index,
    output logic [23:0]      width,
    output logic [23:0]      height,
    output logic [23:0]      depth,
    output logic [31:0]      payload_bytes
);

    logic [31:0]      file_length_reg;
    logic [31:0]      file_length_next;
    logic             q_push;
    logic             q_pop;
    ahp_pkg::rec_t    front_rec;
    ahp_pkg::rec_t    back_rec;
    ahp_pkg::q_stat_t q_stat;

    assign cfg_ready        = 1'b1;
    assign file_length_next = (cfg_valid && cfg_ready) ? cfg_data : file_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= 32'd0;
        end
        else
        begin
            file_length_reg <= file_length_next;
        end
    end

    ahp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .header_byte (header_byte),
        .file_length (file_length_reg),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_rec       (front_rec)
    );

    ahp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data (front_rec),
        .rd      (q_pop),
        .rd_data (back_rec),
        .stat    (q_stat)
    );

    ahp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .q_rec         (back_rec),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .status        (status),
        .format_index  (format_index),
        .width         (width),
        .height        (height),
        .depth         (depth),
        .payload_bytes (payload_bytes)
    );

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("header pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("back end took a header from an empty queue");

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ahp_pkg::STATUS_OK) |->
        (format_index == 4'd0 && width == 24'd0 && height == 24'd0 &&
         depth == 24'd0 && payload_bytes == 32'd0))
        else $error("failed header carries non-zero fields");

    a_ok_fields_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ahp_pkg::STATUS_OK) |->
        (format_index <= 4'd13 && payload_bytes[3:0] == 4'd0))
        else $error("successful result has bad format index or payload size");
`endif

endmodule

`default_nettype wire

// ===== rtl/ahp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ahp_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [7:0]       header_byte,
    input  wire logic [31:0]      file_length,
    input  wire ahp_pkg::q_stat_t q_stat,
    output logic                  q_push,
    output ahp_pkg::rec_t         q_rec
);

    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [7:0]  hdr_reg [15];
    logic        accept;
    logic        last;
    logic [31:0] magic;
    logic [4:0]  fmt_hit;
    logic [31:0] body_len;

    assign last   = (pos_reg == ahp_pkg::LAST_POS);
    // hold the last byte only while both queue slots are taken
    assign full   = last && q_stat.full;
    assign accept = push && !full;
    assign q_push = accept && last;

    assign pos_next = accept ? pos_reg + 4'd1 : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 4'd0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !last)
        begin
            hdr_reg[pos_reg] <= header_byte;
        end
    end

    // classify on the sixteenth byte, checks in header order
    always_comb
    begin
        magic    = {hdr_reg[3], hdr_reg[2], hdr_reg[1], hdr_reg[0]};
        fmt_hit  = ahp_pkg::fmt_lookup(hdr_reg[4], hdr_reg[5]);
        body_len = file_length - ahp_pkg::HDR_LEN;

        q_rec.fmt    = fmt_hit[3:0];
        q_rec.bx     = hdr_reg[4][3:0];
        q_rec.by     = hdr_reg[5][3:0];
        q_rec.width  = {hdr_reg[9], hdr_reg[8], hdr_reg[7]};
        q_rec.height = {hdr_reg[12], hdr_reg[11], hdr_reg[10]};
        q_rec.depth  = {header_byte, hdr_reg[14], hdr_reg[13]};
        q_rec.avail  = body_len[31:4];

        if (file_length <= ahp_pkg::HDR_LEN)
        begin
            q_rec.pre_status = ahp_pkg::STATUS_TOO_SHORT;
        end
        else if (magic != ahp_pkg::MAGIC_WORD)
        begin
            q_rec.pre_status = ahp_pkg::STATUS_BAD_MAGIC;
        end
        else if (hdr_reg[6] > 8'd1 || !fmt_hit[4])
        begin
            q_rec.pre_status = ahp_pkg::STATUS_BAD_DIMS;
        end
        else
        begin
            q_rec.pre_status = ahp_pkg::STATUS_OK;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ahp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ahp_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire ahp_pkg::rec_t    wr_data,
    input  wire logic             rd,
    output ahp_pkg::rec_t         rd_data,
    output ahp_pkg::q_stat_t      stat
);

    ahp_pkg::rec_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign rd_data    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ahp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ahp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ahp_pkg::q_stat_t q_stat,
    input  wire ahp_pkg::rec_t    q_rec,
    output logic                  q_pop,
    output logic                  empty,
    input  wire logic             pop,
    output logic [2:0]            status,
    output logic [3:0]            format_index,
    output logic [23:0]           width,
    output logic [23:0]           height,
    output logic [23:0]           depth,
    output logic [31:0]           payload_bytes
);

    localparam logic [2:0] LAST_STEP = 3'd6;

    ahp_pkg::back_state_t state_reg;
    ahp_pkg::back_state_t state_next;
    logic [2:0]           cnt_reg;
    logic [2:0]           cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    ahp_pkg::rec_t rec_reg;
    logic [27:0]   divx_reg;
    logic [27:0]   divy_reg;
    logic [3:0]    remx_reg;
    logic [3:0]    remy_reg;
    logic [27:0]   qx_reg;
    logic [27:0]   qy_reg;
    logic [45:0]   xy_reg;
    logic [51:0]   prod_reg;
    logic          big_reg;

    logic [7:0]    sx;
    logic [7:0]    sy;
    logic [24:0]   ceil_x;
    logic [24:0]   ceil_y;
    logic          load;
    logic          step;
    logic          out_free;
    logic          out_load;
    logic [2:0]    fin_status;

    // one radix-16 restoring step: returns {remainder, four quotient bits}
    function automatic logic [7:0] div_step(input logic [3:0] rem, input logic [3:0] bits,
                                            input logic [3:0] dv);
        logic [4:0] t;
        logic [3:0] r;
        logic [3:0] q;
        r = rem;
        q = 4'd0;
        for (int k = 3; k >= 0; k--) begin
            t = {r, bits[k]};
            if (t >= {1'b0, dv}) begin
                t    = t - {1'b0, dv};
                q[k] = 1'b1;
            end
            r = t[3:0];
        end
        return {r, q};
    endfunction

    assign sx     = div_step(remx_reg, divx_reg[27:24], rec_reg.bx);
    assign sy     = div_step(remy_reg, divy_reg[27:24], rec_reg.by);
    assign ceil_x = {1'b0, q_rec.width} + {21'd0, q_rec.bx} - 25'd1;
    assign ceil_y = {1'b0, q_rec.height} + {21'd0, q_rec.by} - 25'd1;

    assign empty    = !out_valid_reg;
    assign out_free = !out_valid_reg || pop;
    assign load     = (state_reg == ahp_pkg::S_IDLE) && !q_stat.empty;
    assign q_pop    = load;
    assign step     = (state_reg == ahp_pkg::S_DIV);
    assign out_load = (state_reg == ahp_pkg::S_FINISH) && out_free;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ahp_pkg::S_IDLE:
            begin
                cnt_next = 3'd0;
                if (!q_stat.empty)
                begin
                    state_next = (q_rec.pre_status == ahp_pkg::STATUS_OK) ?
                                 ahp_pkg::S_DIV : ahp_pkg::S_FINISH;
                end
            end
            ahp_pkg::S_DIV:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ahp_pkg::S_MUL_XY;
                end
            end
            ahp_pkg::S_MUL_XY:
            begin
                state_next = ahp_pkg::S_MUL_Z;
            end
            ahp_pkg::S_MUL_Z:
            begin
                state_next = ahp_pkg::S_FINISH;
            end
            ahp_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ahp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ahp_pkg::S_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    // first failing check wins; payload must fit in what follows the header
    always_comb
    begin
        if (rec_reg.pre_status != ahp_pkg::STATUS_OK)
        begin
            fin_status = rec_reg.pre_status;
        end
        else if (big_reg || prod_reg > {24'd0, rec_reg.avail})
        begin
            fin_status = ahp_pkg::STATUS_TOO_SMALL;
        end
        else
        begin
            fin_status = ahp_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ahp_pkg::S_IDLE;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg  <= q_rec;
            divx_reg <= {3'd0, ceil_x};
            divy_reg <= {3'd0, ceil_y};
            remx_reg <= 4'd0;
            remy_reg <= 4'd0;
            qx_reg   <= 28'd0;
            qy_reg   <= 28'd0;
        end
        if (step)
        begin
            divx_reg <= {divx_reg[23:0], 4'd0};
            divy_reg <= {divy_reg[23:0], 4'd0};
            remx_reg <= sx[7:4];
            remy_reg <= sy[7:4];
            qx_reg   <= {qx_reg[23:0], sx[3:0]};
            qy_reg   <= {qy_reg[23:0], sy[3:0]};
        end
        if (state_reg == ahp_pkg::S_MUL_XY)
        begin
            xy_reg <= qx_reg[22:0] * qy_reg[22:0];
        end
        if (state_reg == ahp_pkg::S_MUL_Z)
        begin
            // a block count of 2^28 or more can never fit a 32-bit file
            big_reg  <= (xy_reg[45:28] != 18'd0) && (rec_reg.depth != 24'd0);
            prod_reg <= xy_reg[27:0] * rec_reg.depth;
        end
        if (out_load)
        begin
            status <= fin_status;
            if (fin_status == ahp_pkg::STATUS_OK)
            begin
                format_index  <= rec_reg.fmt;
                width         <= rec_reg.width;
                height        <= rec_reg.height;
                depth         <= rec_reg.depth;
                payload_bytes <= {prod_reg[27:0], 4'd0};
            end
            else
            begin
                format_index  <= 4'd0;
                width         <= 24'd0;
                height        <= 24'd0;
                depth         <= 24'd0;
                payload_bytes <= 32'd0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 800;

    typedef enum logic [3:0] {
        FMT_4X4, FMT_5X4, FMT_5X5, FMT_6X5, FMT_6X6, FMT_8X5, FMT_8X6, FMT_8X8,
        FMT_10X5, FMT_10X6, FMT_10X8, FMT_10X10, FMT_12X10, FMT_12X12
    } blk_fmt_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  fmt;
        logic [23:0] width;
        logic [23:0] height;
        logic [23:0] depth;
        logic [31:0] payload;
    } decoded_t;

    typedef struct {
        logic [31:0]  flen;
        logic [127:0] hdr;
        bit           typed;
        logic [2:0]   st;
        blk_fmt_t     fmt;
    } hdr_row_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  header_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        empty;
    logic        pop;
    logic [2:0]  status;
    logic [3:0]  format_index;
    logic [23:0] width;
    logic [23:0] height;
    logic [23:0] depth;
    logic [31:0] payload_bytes;

    decoded_t     decoded_due[$];
    hdr_row_t     hdr_rows[$];
    logic [31:0]  cur_flen;
    logic [127:0] hdr_acc;
    int           hdr_fill;
    bit           typed_pending;
    decoded_t     typed_res;
    bit           steady_flow;
    int           mismatches;

    astc_header_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .header_byte   (header_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .empty         (empty),
        .pop           (pop),
        .status        (status),
        .format_index  (format_index),
        .width         (width),
        .height        (height),
        .depth         (depth),
        .payload_bytes (payload_bytes)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [15:0] block_dims(input blk_fmt_t f);
        case (f)
            FMT_4X4:   return {8'd4, 8'd4};
            FMT_5X4:   return {8'd5, 8'd4};
            FMT_5X5:   return {8'd5, 8'd5};
            FMT_6X5:   return {8'd6, 8'd5};
            FMT_6X6:   return {8'd6, 8'd6};
            FMT_8X5:   return {8'd8, 8'd5};
            FMT_8X6:   return {8'd8, 8'd6};
            FMT_8X8:   return {8'd8, 8'd8};
            FMT_10X5:  return {8'd10, 8'd5};
            FMT_10X6:  return {8'd10, 8'd6};
            FMT_10X8:  return {8'd10, 8'd8};
            FMT_10X10: return {8'd10, 8'd10};
            FMT_12X10: return {8'd12, 8'd10};
            FMT_12X12: return {8'd12, 8'd12};
            default:   return 16'h0000;
        endcase
    endfunction

    // {hit, index}
    function automatic logic [4:0] format_of(input logic [7:0] bx, input logic [7:0] by);
        for (int i = 0; i < 14; i++)
        begin
            if (block_dims(blk_fmt_t'(i)) == {bx, by})
                return {1'b1, 4'(i)};
        end
        return 5'd0;
    endfunction

    function automatic logic [127:0] mk_header(input logic [31:0] magic, input logic [7:0] bx,
                                               input logic [7:0] by, input logic [7:0] bz,
                                               input logic [23:0] w, input logic [23:0] h,
                                               input logic [23:0] d);
        return {d, h, w, bz, by, bx, magic};
    endfunction

    function automatic decoded_t decode_header(input logic [127:0] hb, input logic [31:0] flen);
        decoded_t    r;
        logic [7:0]  bx;
        logic [7:0]  by;
        logic [7:0]  bz;
        logic [4:0]  hit;
        logic [23:0] w;
        logic [23:0] h;
        logic [23:0] d;
        logic [63:0] nx;
        logic [63:0] ny;
        logic [63:0] nz;
        logic [63:0] xy;
        logic [63:0] avail;
        r   = '0;
        bx  = hb[39:32];
        by  = hb[47:40];
        bz  = hb[55:48];
        w   = hb[79:56];
        h   = hb[103:80];
        d   = hb[127:104];
        hit = format_of(bx, by);
        if (flen <= ahp_pkg::HDR_LEN)
            r.status = ahp_pkg::STATUS_TOO_SHORT;
        else if (hb[31:0] != ahp_pkg::MAGIC_WORD)
            r.status = ahp_pkg::STATUS_BAD_MAGIC;
        else if (bz > 8'd1 || !hit[4])
            r.status = ahp_pkg::STATUS_BAD_DIMS;
        else
        begin
            if (bz == 8'd0)
                bz = 8'd1;
            nx    = (64'(w) + 64'(bx) - 64'd1) / 64'(bx);
            ny    = (64'(h) + 64'(by) - 64'd1) / 64'(by);
            nz    = (64'(d) + 64'(bz) - 64'd1) / 64'(bz);
            xy    = nx * ny;
            avail = 64'(flen - ahp_pkg::HDR_LEN) >> 4;
            // exact comparison, no wrap
            if (nz != 64'd0 && xy > avail / nz)
                r.status = ahp_pkg::STATUS_TOO_SMALL;
            else
            begin
                r.status  = ahp_pkg::STATUS_OK;
                r.fmt     = hit[3:0];
                r.width   = w;
                r.height  = h;
                r.depth   = d;
                r.payload = 32'(xy * nz * 64'd16);
            end
        end
        return r;
    endfunction

    function automatic logic [23:0] rand_dim(input int maxbits);
        int bits;
        if ($urandom_range(0, 15) == 0)
            return 24'hFFFFFF;
        bits = $urandom_range(0, maxbits);
        return 24'($urandom & ((32'h1 << bits) - 32'h1));
    endfunction

    function automatic logic [127:0] random_header();
        logic [31:0] magic;
        logic [15:0] bxy;
        logic [7:0]  bz;
        int          kind;
        kind  = $urandom_range(0, 19);
        magic = ahp_pkg::MAGIC_WORD;
        bxy   = block_dims(blk_fmt_t'($urandom_range(0, 13)));
        bz    = 8'($urandom_range(0, 1));
        case (kind)
            0: return {$urandom, $urandom, $urandom, $urandom};
            1: magic = magic ^ (32'h1 << $urandom_range(0, 31));
            2: bxy = 16'($urandom);
            3: bz = 8'($urandom_range(2, 255));
            4: bxy = {bxy[7:0], bxy[15:8]};
            default: ;
        endcase
        return mk_header(magic, bxy[15:8], bxy[7:0], bz, rand_dim(24), rand_dim(24),
                         rand_dim(10));
    endfunction

    function automatic int draw_idle();
        if (steady_flow)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 18);
        return $urandom_range(0, 2);
    endfunction

    task automatic add_row(input logic [31:0] flen, input logic [127:0] hdr, input bit typed,
                           input logic [2:0] st, input blk_fmt_t fmt);
        hdr_row_t row;
        row.flen  = flen;
        row.hdr   = hdr;
        row.typed = typed;
        row.st    = st;
        row.fmt   = fmt;
        hdr_rows.push_back(row);
    endtask

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = draw_idle();
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push        <= 1'b1;
        header_byte <= b;
        do @(posedge clk); while (full);
        hdr_acc[8*hdr_fill +: 8] = b;
        hdr_fill++;
        if (hdr_fill == 16)
        begin
            hdr_fill = 0;
            if (typed_pending)
                decoded_due.push_back(typed_res);
            else
                decoded_due.push_back(decode_header(hdr_acc, cur_flen));
            typed_pending = 1'b0;
        end
    endtask

    task automatic send_header(input logic [127:0] hdr);
        for (int i = 0; i < 16; i++)
            push_byte(hdr[8*i +: 8]);
    endtask

    // drop push, drain every result, then let the back end fall quiet
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (decoded_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_file_length(input logic [31:0] v);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cur_flen = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [31:0] flen;
        logic [31:0] mask;
        rst_n         = 1'b0;
        push          = 1'b0;
        header_byte   = 8'h00;
        cfg_valid     = 1'b0;
        cfg_data      = 32'h0;
        cur_flen      = 32'h0;
        hdr_acc       = '0;
        hdr_fill      = 0;
        typed_pending = 1'b0;
        typed_res     = '0;
        steady_flow   = 1'b0;
        mismatches    = 0;

        add_row(32'd0, mk_header(ahp_pkg::MAGIC_WORD, 8'd4, 8'd4, 8'd1, 24'd8, 24'd8, 24'd1),
                1'b1, ahp_pkg::STATUS_TOO_SHORT, FMT_4X4);
        add_row(32'd16, mk_header(ahp_pkg::MAGIC_WORD, 8'd4, 8'd4, 8'd1, 24'd8, 24'd8, 24'd1),
                1'b1, ahp_pkg::STATUS_TOO_SHORT, FMT_4X4);
        add_row(32'd17, '0, 1'b1, ahp_pkg::STATUS_BAD_MAGIC, FMT_4X4);
        add_row(32'd17, '1, 1'b1, ahp_pkg::STATUS_BAD_MAGIC, FMT_4X4);
        add_row(32'd17, mk_header(ahp_pkg::MAGIC_WORD ^ 32'h1, 8'd4, 8'd4, 8'd1,
                                  24'd1, 24'd1, 24'd1),
                1'b1, ahp_pkg::STATUS_BAD_MAGIC, FMT_4X4);
        add_row(32'd17, mk_header(ahp_pkg::MAGIC_WORD, 8'd3, 8'd3, 8'd1, 24'd1, 24'd1, 24'd1),
                1'b1, ahp_pkg::STATUS_BAD_DIMS, FMT_4X4);
        add_row(32'd17, mk_header(ahp_pkg::MAGIC_WORD, 8'd4, 8'd4, 8'd2, 24'd1, 24'd1, 24'd1),
                1'b1, ahp_pkg::STATUS_BAD_DIMS, FMT_4X4);
        add_row(32'd17, mk_header(ahp_pkg::MAGIC_WORD, 8'd0, 8'd0, 8'd0, 24'd1, 24'd1, 24'd1),
                1'b1, ahp_pkg::STATUS_BAD_DIMS, FMT_4X4);
        // block Z of zero taken as one, zero-sized image
        add_row(32'd17, mk_header(ahp_pkg::MAGIC_WORD, 8'd4, 8'd4, 8'd0, 24'd0, 24'd0, 24'd0),
                1'b1, ahp_pkg::STATUS_OK, FMT_4X4);
        add_row(32'd17, mk_header(ahp_pkg::MAGIC_WORD, 8'd4, 8'd4, 8'd1, 24'd1, 24'd1, 24'd1),
                1'b1, ahp_pkg::STATUS_TOO_SMALL, FMT_4X4);
        add_row(32'd32, mk_header(ahp_pkg::MAGIC_WORD, 8'd4, 8'd4, 8'd1, 24'd1, 24'd1, 24'd1),
                1'b0, ahp_pkg::STATUS_OK, FMT_4X4);
        // payload exactly fills the file, then one byte short
        add_row(32'd4112, mk_header(ahp_pkg::MAGIC_WORD, 8'd4, 8'd4, 8'd1,
                                    24'd64, 24'd64, 24'd1),
                1'b0, ahp_pkg::STATUS_OK, FMT_4X4);
        add_row(32'd4111, mk_header(ahp_pkg::MAGIC_WORD, 8'd4, 8'd4, 8'd1,
                                    24'd64, 24'd64, 24'd1),
                1'b0, ahp_pkg::STATUS_OK, FMT_4X4);
        add_row(32'hFFFFFFFF, mk_header(ahp_pkg::MAGIC_WORD, 8'd12, 8'd12, 8'd1, 24'hFFFFFF,
                                        24'hFFFFFF, 24'hFFFFFF),
                1'b1, ahp_pkg::STATUS_TOO_SMALL, FMT_12X12);
        add_row(32'hFFFFFFFF, mk_header(ahp_pkg::MAGIC_WORD, 8'd12, 8'd12, 8'd0, 24'hFFFFFF,
                                        24'd12, 24'd1),
                1'b0, ahp_pkg::STATUS_OK, FMT_12X12);
        add_row(32'hFFFFFFFF, mk_header(ahp_pkg::MAGIC_WORD, 8'd5, 8'd4, 8'd0, 24'd0,
                                        24'hFFFFFF, 24'hFFFFFF),
                1'b0, ahp_pkg::STATUS_OK, FMT_5X4);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (hdr_rows[i])
        begin
            if (i == 0 || hdr_rows[i].flen != cur_flen)
                write_file_length(hdr_rows[i].flen);
            // failure fields stay zero
            typed_res        = '0;
            typed_res.status = hdr_rows[i].st;
            if (hdr_rows[i].st == ahp_pkg::STATUS_OK)
                typed_res.fmt = hdr_rows[i].fmt;
            typed_pending = hdr_rows[i].typed;
            send_header(hdr_rows[i].hdr);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: flen = 32'hFFFFFFFF;
                1: flen = 32'($urandom_range(0, 16));
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        flen = $urandom;
                    else
                    begin
                        mask = (32'h1 << $urandom_range(4, 31)) - 32'h1;
                        flen = ahp_pkg::HDR_LEN + ($urandom & mask);
                    end
                end
            endcase
            write_file_length(flen);
            steady_flow = (ph % 4 == 2);
            repeat (8) send_header(random_header());
        end

        steady_flow = 1'b0;
        settle();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin : result_side
        int       gap;
        int       popped;
        decoded_t exp;
        pop    = 1'b0;
        popped = 0;
        @(posedge rst_n);
        forever
        begin
            // hold off once for long enough that the header path backs up
            gap = (popped == 32) ? LONG_HOLD : draw_idle();
            @(negedge clk);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            popped++;
            if (decoded_due.size() == 0)
            begin
                $error("result item with nothing expected: status %0d", status);
                mismatches++;
            end
            else
            begin
                exp = decoded_due.pop_front();
                if (status !== exp.status)
                begin
                    $error("status: expected %0d, got %0d", exp.status, status);
                    mismatches++;
                end
                if (format_index !== exp.fmt)
                begin
                    $error("format_index: expected %0d, got %0d", exp.fmt, format_index);
                    mismatches++;
                end
                if (width !== exp.width)
                begin
                    $error("width: expected %0d, got %0d", exp.width, width);
                    mismatches++;
                end
                if (height !== exp.height)
                begin
                    $error("height: expected %0d, got %0d", exp.height, height);
                    mismatches++;
                end
                if (depth !== exp.depth)
                begin
                    $error("depth: expected %0d, got %0d", exp.depth, depth);
                    mismatches++;
                end
                if (payload_bytes !== exp.payload)
                begin
                    $error("payload_bytes: expected %0d, got %0d", exp.payload, payload_bytes);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ahp_pkg.sv
rtl/ahp_front.sv
rtl/ahp_queue.sv
rtl/ahp_back.sv
rtl/astc_header_parser.sv
tb/sv/testbench.sv
